// ===== design/sad_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite attribute decoder package
// Shared register indexes, height codes and the structs passed between the
// decode logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sad_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_COLOR_MASK     = 3'd0;
   localparam logic [2:0] REG_PRIORITY_MASK  = 3'd1;
   localparam logic [2:0] REG_PRIORITY_VALUE = 3'd2;
   localparam logic [2:0] REG_FLIP_SCREEN    = 3'd3;
   localparam logic [2:0] REG_HEIGHT_TABLE   = 3'd4;

   // Height codes held in the packed height table.
   localparam logic [1:0] HEIGHT_SINGLE = 2'd0;
   localparam logic [1:0] HEIGHT_DOUBLE = 2'd1;
   localparam logic [1:0] HEIGHT_QUAD   = 2'd2;
   localparam logic [1:0] HEIGHT_RAW    = 2'd3;

   // Position constants, all taken modulo 1024.
   localparam logic [9:0] Y_ORIGIN     = 10'd369;
   localparam logic [9:0] X_MIRROR     = 10'd496;
   localparam logic [9:0] Y_MIRROR     = 10'd242;
   localparam logic [9:0] DOUBLE_SHIFT = 10'd16;
   localparam logic [9:0] QUAD_SHIFT   = 10'd48;

   typedef struct packed {
      logic [4:0]  color_mask;
      logic [7:0]  priority_mask;
      logic [7:0]  priority_value;
      logic        flip_screen;
      logic [63:0] height_table;
   } csr_type;

   // One decoded sprite, ready to be split into 16-pixel pieces.
   typedef struct packed {
      logic [10:0] code;
      logic [4:0]  color;
      logic        flip_x;
      logic        flip_y;
      logic [9:0]  x_pos;
      logic [9:0]  y_pos;
      logic [1:0]  last_index;
   } sprite_type;

endpackage

`default_nettype wire

// ===== design/sad_decode.sv =====
// ----------------------------------------------------------------------------
// Sprite entry decode
// Checks the priority bits of one sprite list entry and decodes its tile
// code, color, flips, position and piece count.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_decode (
   input  wire  sad_pkg::csr_type    csr,
   input  wire  logic [7:0]          attr_byte,
   input  wire  logic [7:0]          code_low,
   input  wire  logic [7:0]          code_flags,
   input  wire  logic [7:0]          x_low,
   input  wire  logic                x_high,
   input  wire  logic [7:0]          y_low,
   input  wire  logic                y_high,
   output logic                      selected,
   output sad_pkg::sprite_type       sprite
);

   logic [10:0] raw_code;
   logic [4:0]  height_sel;
   logic [1:0]  height;
   logic [10:0] code;
   logic [9:0]  sx;
   logic [9:0]  sy;
   logic [9:0]  sy_shifted;
   logic [1:0]  last_index;

   assign selected   = (attr_byte & csr.priority_mask) == csr.priority_value;
   assign raw_code   = {code_flags[2:0], code_low};
   assign height_sel = raw_code[9:5];
   assign height     = csr.height_table[{height_sel, 1'b0} +: 2];

   always_comb begin
      code       = raw_code;
      sy         = sad_pkg::Y_ORIGIN - {1'b0, y_high, y_low};
      last_index = 2'd0;
      unique case (height)
         sad_pkg::HEIGHT_SINGLE: begin
            last_index = 2'd0;
         end
         sad_pkg::HEIGHT_DOUBLE: begin
            code[0]    = 1'b0;
            sy         = sy - sad_pkg::DOUBLE_SHIFT;
            last_index = 2'd1;
         end
         sad_pkg::HEIGHT_QUAD: begin
            code[1:0]  = 2'b00;
            sy         = sy - sad_pkg::QUAD_SHIFT;
            last_index = 2'd3;
         end
         sad_pkg::HEIGHT_RAW: begin
            last_index = 2'd3;
         end
         default: begin
            last_index = 2'd0;
         end
      endcase
   end

   // Screen flip mirrors the whole sprite box, so the top row moves by its
   // full height as well.
   assign sy_shifted = sad_pkg::Y_MIRROR - {4'd0, last_index, 4'd0} - sy;
   assign sx         = csr.flip_screen ? sad_pkg::X_MIRROR - {1'b0, x_high, x_low}
                                       : {1'b0, x_high, x_low};

   always_comb begin
      sprite.code       = code;
      sprite.color      = attr_byte[4:0] & csr.color_mask;
      sprite.flip_x     = code_flags[6] ^ csr.flip_screen;
      sprite.flip_y     = code_flags[7] ^ csr.flip_screen;
      sprite.x_pos      = sx;
      sprite.y_pos      = csr.flip_screen ? sy_shifted : sy;
      sprite.last_index = last_index;
   end

endmodule

`default_nettype wire

// ===== design/sprite_attribute_decoder.sv =====
// ----------------------------------------------------------------------------
// Sprite attribute decoder
// Turns sprite list entries into 16-pixel-tall piece descriptors.
// ----------------------------------------------------------------------------
// An accepted entry is decoded in the cycle it arrives and held in a sprite
// register; from there one piece descriptor per cycle moves into the output
// register while the output is not stalled, highest row first, so an entry
// yields one, two or four pieces depending on its height code (four for
// height codes two and three). The next entry is accepted in the same
// cycle as the last piece of the current one leaves the emitter, and an
// entry that fails the priority check is accepted without producing a
// transaction. The first piece reaches the outputs through the sprite
// register and then the output register.
`default_nettype none

module sprite_attribute_decoder (
   input  wire  logic               clock,
   input  wire  logic               reset,
   // Configuration.
   input  wire  logic               csr_write_enable,
   input  wire  logic [2:0]         csr_index,
   input  wire  logic [63:0]        csr_write_data,
   // Sprite entries.
   input  wire  logic               req_valid,
   output logic                     req_stall,
   input  wire  logic [7:0]         req_attr_byte,
   input  wire  logic [7:0]         req_code_low,
   input  wire  logic [7:0]         req_code_flags,
   input  wire  logic [7:0]         req_x_low,
   input  wire  logic               req_x_high,
   input  wire  logic [7:0]         req_y_low,
   input  wire  logic               req_y_high,
   // Piece descriptors.
   output logic                     rsp_valid,
   input  wire  logic               rsp_stall,
   output logic [10:0]              rsp_tile_code,
   output logic [4:0]               rsp_color,
   output logic                     rsp_flip_x,
   output logic                     rsp_flip_y,
   output logic signed [9:0]        rsp_x_pos,
   output logic signed [9:0]        rsp_y_pos,
   output logic                     rsp_last_piece
);

   sad_pkg::csr_type    csr_ff;
   sad_pkg::sprite_type decoded;
   logic                selected;

   sad_pkg::sprite_type sprite_ff;
   logic                sprite_valid_ff;
   logic                sprite_valid_in;
   logic [1:0]          piece_ff;
   logic [1:0]          piece_in;

   logic                out_free;
   logic                emit;
   logic                emit_last;
   logic                req_accept;
   logic [1:0]          piece_offset;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [10:0]         tile_code_ff;
   logic [4:0]          color_ff;
   logic                flip_x_ff;
   logic                flip_y_ff;
   logic [9:0]          x_pos_ff;
   logic [9:0]          y_pos_ff;
   logic                last_piece_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.color_mask     <= 5'h1f;
         csr_ff.priority_mask  <= 8'h00;
         csr_ff.priority_value <= 8'h00;
         csr_ff.flip_screen    <= 1'b0;
         csr_ff.height_table   <= 64'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sad_pkg::REG_COLOR_MASK:     csr_ff.color_mask     <= csr_write_data[4:0];
            sad_pkg::REG_PRIORITY_MASK:  csr_ff.priority_mask  <= csr_write_data[7:0];
            sad_pkg::REG_PRIORITY_VALUE: csr_ff.priority_value <= csr_write_data[7:0];
            sad_pkg::REG_FLIP_SCREEN:    csr_ff.flip_screen    <= csr_write_data[0];
            sad_pkg::REG_HEIGHT_TABLE:   csr_ff.height_table   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   sad_decode u_decode (
      .csr        (csr_ff),
      .attr_byte  (req_attr_byte),
      .code_low   (req_code_low),
      .code_flags (req_code_flags),
      .x_low      (req_x_low),
      .x_high     (req_x_high),
      .y_low      (req_y_low),
      .y_high     (req_y_high),
      .selected   (selected),
      .sprite     (decoded)
   );

   // Piece emitter handshake.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = sprite_valid_ff && out_free;
   assign emit_last  = emit && (piece_ff == 2'd0);
   assign req_stall  = sprite_valid_ff && !emit_last;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      sprite_valid_in = sprite_valid_ff;
      piece_in        = piece_ff;
      if (emit) begin
         piece_in = piece_ff - 2'd1;
         if (emit_last) begin
            sprite_valid_in = 1'b0;
         end
      end
      if (req_accept && selected) begin
         sprite_valid_in = 1'b1;
         piece_in        = decoded.last_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_valid_ff <= 1'b0;
         piece_ff        <= 2'd0;
      end else begin
         sprite_valid_ff <= sprite_valid_in;
         piece_ff        <= piece_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && selected) begin
         sprite_ff <= decoded;
      end
   end

   // Pieces count upward in tile code from the top row, or downward when the
   // sprite is drawn mirrored vertically.
   assign piece_offset = sprite_ff.flip_y ? sprite_ff.last_index - piece_ff : piece_ff;
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tile_code_ff  <= sprite_ff.code + {9'd0, piece_offset};
         color_ff      <= sprite_ff.color;
         flip_x_ff     <= sprite_ff.flip_x;
         flip_y_ff     <= sprite_ff.flip_y;
         x_pos_ff      <= sprite_ff.x_pos;
         y_pos_ff      <= sprite_ff.y_pos + {4'd0, piece_ff, 4'd0};
         last_piece_ff <= (piece_ff == 2'd0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_code  = tile_code_ff;
   assign rsp_color      = color_ff;
   assign rsp_flip_x     = flip_x_ff;
   assign rsp_flip_y     = flip_y_ff;
   assign rsp_x_pos      = $signed(x_pos_ff);
   assign rsp_y_pos      = $signed(y_pos_ff);
   assign rsp_last_piece = last_piece_ff;

   // A piece that is not the last one always leaves more of its sprite behind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_piece_ff |-> sprite_valid_ff)
      else $error("non-final piece with no sprite pending");

   // The remaining piece count never exceeds the sprite's piece count.
   assert property (@(posedge clock) disable iff (reset)
      sprite_valid_ff |-> piece_ff <= sprite_ff.last_index)
      else $error("piece index beyond sprite height");

   // Consecutive pieces of one sprite step up by one row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !last_piece_ff |=>
         rsp_valid_ff && (y_pos_ff == 10'($past(y_pos_ff) - 10'd16))
         && (x_pos_ff == $past(x_pos_ff)))
      else $error("pieces of one sprite out of sequence");

endmodule

`default_nettype wire
